@@ hdl/hcbd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_pkg
// types, region codes and the address decoder shared by the bus decoder
// ----------------------------------------------------------------------------
package hcbd_pkg;

  typedef enum logic [1:0] {
    KIND_READ      = 2'd0,
    KIND_WRITE     = 2'd1,
    KIND_LOAD_ROM  = 2'd2,
    KIND_LOAD_BOOT = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    SRC_ZERO = 2'd0,
    SRC_RAM  = 2'd1,
    SRC_IE   = 2'd2
  } src_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_HI   = 2'd1,
    ST_DONE = 2'd2
  } state_e;

  localparam logic [3:0] REGION_NONE    = 4'd0;
  localparam logic [3:0] REGION_VRAM    = 4'd1;
  localparam logic [3:0] REGION_ERAM    = 4'd2;
  localparam logic [3:0] REGION_WRAM    = 4'd3;
  localparam logic [3:0] REGION_ECHO    = 4'd4;
  localparam logic [3:0] REGION_OAM     = 4'd5;
  localparam logic [3:0] REGION_IO      = 4'd6;
  localparam logic [3:0] REGION_DISPLAY = 4'd7;
  localparam logic [3:0] REGION_HRAM    = 4'd8;
  localparam logic [3:0] REGION_IE      = 4'd9;

  localparam logic [15:0] ADDR_VRAM      = 16'h8000;
  localparam logic [15:0] ADDR_ERAM      = 16'hA000;
  localparam logic [15:0] ADDR_WRAM      = 16'hC000;
  localparam logic [15:0] ADDR_ECHO      = 16'hE000;
  localparam logic [15:0] ADDR_OAM       = 16'hFE00;
  localparam logic [15:0] ADDR_OAM_END   = 16'hFEA0;
  localparam logic [15:0] ADDR_IO        = 16'hFF00;
  localparam logic [15:0] ADDR_IO_END    = 16'hFF10;
  localparam logic [15:0] ADDR_DISPLAY   = 16'hFF40;
  localparam logic [15:0] ADDR_HRAM      = 16'hFF80;
  localparam logic [15:0] ADDR_IE        = 16'hFFFF;
  localparam logic [15:0] ECHO_OFFSET    = 16'h2000;
  localparam logic [15:0] BOOT_SIZE      = 16'h0100;
  // boot rom lives in the physical slot that the echo window never reaches
  localparam logic [7:0]  BOOT_PHYS_PAGE = 8'hE0;

  localparam int unsigned RAM_DEPTH = 65536;

  typedef struct packed {
    kind_e       kind;
    logic        is_word;
    logic [15:0] address;
    logic [15:0] write_data;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [3:0]  write_region;
  } out_beat_t;

  // one byte access as seen by the memory
  typedef struct packed {
    logic        re;
    logic        we;
    logic        ie_we;
    src_e        src;
    logic [3:0]  region;
    logic [15:0] phys;
  } acc_t;

  function automatic acc_t decode(kind_e kind, logic [15:0] a, logic ovl);
    acc_t        r;
    logic        boot_pg;
    logic        mapped;
    logic        rom;
    logic        is_ie;
    logic [3:0]  rgn;
    logic [15:0] phys;
    r       = '0;
    r.src   = SRC_ZERO;
    boot_pg = ovl && (a[15:8] == 8'h00);
    mapped  = 1'b1;
    rom     = 1'b0;
    is_ie   = 1'b0;
    rgn     = REGION_NONE;
    phys    = a;
    priority if (a < ADDR_VRAM) begin
      rom = 1'b1;
    end else if (a < ADDR_ERAM) begin
      rgn = REGION_VRAM;
    end else if (a < ADDR_WRAM) begin
      rgn = REGION_ERAM;
    end else if (a < ADDR_ECHO) begin
      rgn = REGION_WRAM;
    end else if (a < ADDR_OAM) begin
      rgn  = REGION_ECHO;
      phys = a - ECHO_OFFSET;
    end else if (a < ADDR_OAM_END) begin
      rgn = REGION_OAM;
    end else if (a < ADDR_IO) begin
      mapped = 1'b0;
    end else if (a == ADDR_IE) begin
      rgn   = REGION_IE;
      is_ie = 1'b1;
    end else if (a < ADDR_IO_END) begin
      rgn = REGION_IO;
    end else if (a < ADDR_DISPLAY) begin
      mapped = 1'b0;
    end else if (a < ADDR_HRAM) begin
      rgn = REGION_DISPLAY;
    end else begin
      rgn = REGION_HRAM;
    end

    unique case (kind)
      KIND_READ: begin
        if (boot_pg) begin
          r.re   = 1'b1;
          r.src  = SRC_RAM;
          r.phys = {BOOT_PHYS_PAGE, a[7:0]};
        end else if (mapped && is_ie) begin
          r.src = SRC_IE;
        end else if (mapped) begin
          r.re   = 1'b1;
          r.src  = SRC_RAM;
          r.phys = phys;
        end
      end
      KIND_WRITE: begin
        if (!boot_pg && mapped && !rom) begin
          r.region = rgn;
          r.ie_we  = is_ie;
          r.we     = !is_ie;
          r.phys   = phys;
        end
      end
      KIND_LOAD_ROM: begin
        if (a < ADDR_VRAM) begin
          r.we   = 1'b1;
          r.phys = a;
        end
      end
      KIND_LOAD_BOOT: begin
        if (a < BOOT_SIZE) begin
          r.we   = 1'b1;
          r.phys = {BOOT_PHYS_PAGE, a[7:0]};
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/hcbd_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_ram
// single-port synchronous ram, registered read held between reads
// ----------------------------------------------------------------------------
module hcbd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/handheld_console_bus_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// handheld_console_bus_decoder
// memory map decoder for a handheld console bus, one access beat at a time
// ----------------------------------------------------------------------------
// Each input beat is a read, a write, a cartridge rom load or a boot rom load,
// byte or little-endian word. All byte stores sit in one 64k x 8 synchronous
// ram: rom, vram, external ram, work ram, sprite table, io, display and high
// ram at their own bus addresses, the echo window folded onto work ram, and
// the 256-byte boot rom in the physical page at 0xE000 that the echo window
// never addresses. The interrupt-enable register is a flip-flop and resets to
// zero. A word beat makes its low and high byte accesses in turn, because each
// byte needs one access on the single ram port; the result goes to an output
// register, and the next beat is taken in the cycle that result is loaded.
// The config port takes the boot overlay bit at any time (ready is always
// high); a boot rom load also turns the overlay on. There is no clearing pass:
// contents of a store are undefined until written.
// ----------------------------------------------------------------------------
module handheld_console_bus_decoder
  import hcbd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  // access beats
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  // result beats
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o,
  // boot overlay register
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_data_i
);

  state_e      state_q, state_d;
  in_beat_t    item_q;
  src_e        src_q;
  logic [3:0]  region_q;
  logic [7:0]  lo_q;
  logic [7:0]  ie_q;
  logic        ovl_q;
  logic        out_valid_q;
  out_beat_t   out_data_q;

  logic        in_acc;
  logic        out_free;
  logic        out_load;
  logic        issue_hi;
  logic [15:0] addr_hi;
  acc_t        acc0, acc1, cur;
  logic [7:0]  wdata;
  logic [7:0]  ram_rdata;
  logic [7:0]  byte_now;
  logic        ram_en;
  logic        ram_we;
  out_beat_t   result;

  // byte decode: first byte straight from the input, second from the held item
  assign addr_hi = item_q.address + 16'd1;
  assign acc0    = decode(in_data_i.kind, in_data_i.address, ovl_q);
  assign acc1    = decode(item_q.kind, addr_hi, ovl_q);

  assign out_free = !out_valid_q || !out_stall_i;
  assign in_acc   = in_valid_i && !in_stall_o;

  // sequencer
  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    out_load   = 1'b0;
    issue_hi   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
      end
      ST_HI: begin
        issue_hi = 1'b1;
        state_d  = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          in_stall_o = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (in_valid_i && !in_stall_o) begin
      state_d = in_data_i.is_word ? ST_HI : ST_DONE;
    end
  end

  // ram port: at most one byte access per cycle
  always_comb begin
    cur   = '0;
    wdata = item_q.write_data[15:8];
    if (in_acc) begin
      cur   = acc0;
      wdata = in_data_i.write_data[7:0];
    end else if (issue_hi) begin
      cur = acc1;
    end
  end

  assign ram_we = cur.we;
  assign ram_en = cur.we || cur.re;

  hcbd_ram #(
    .Width (8),
    .Depth (RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (cur.phys),
    .wdata_i (wdata),
    .rdata_o (ram_rdata)
  );

  // byte that the last issued access returns
  always_comb begin
    unique case (src_q)
      SRC_RAM: byte_now = ram_rdata;
      SRC_IE:  byte_now = ie_q;
      default: byte_now = 8'h00;
    endcase
  end

  always_comb begin
    result = '0;
    if (item_q.kind == KIND_READ) begin
      result.read_data = item_q.is_word ? {byte_now, lo_q} : {8'h00, byte_now};
    end
    if (item_q.kind == KIND_WRITE) begin
      result.write_region = region_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ovl_q       <= 1'b0;
      ie_q        <= 8'h00;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        ovl_q <= cfg_data_i;
      end else if (in_acc && in_data_i.kind == KIND_LOAD_BOOT) begin
        ovl_q <= 1'b1;
      end
      if (cur.ie_we) begin
        ie_q <= wdata;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // per-item payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q   <= in_data_i;
      src_q    <= acc0.src;
      region_q <= acc0.region;
    end else if (issue_hi) begin
      lo_q     <= byte_now;
      src_q    <= acc1.src;
      region_q <= region_q & acc1.region;
    end
    if (out_load) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign cfg_ready_o = 1'b1;

  // no region code beyond interrupt enable ever leaves the block
  a_region_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.write_region <= REGION_IE))
    else $error("write region code out of range");

  // only reads return data
  a_nonread_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && item_q.kind != KIND_READ) |=> (out_data_o.read_data == 16'h0000))
    else $error("non-read beat returned read data");

  // the ram is idle while a result waits to be loaded, unless a new beat starts
  a_no_write_in_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !in_acc) |-> !ram_we)
    else $error("ram written while finishing a beat");

  // a boot rom load turns the overlay on
  a_boot_overlay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !cfg_valid_i && in_data_i.kind == KIND_LOAD_BOOT) |=> ovl_q)
    else $error("boot load did not set the overlay");

endmodule

@@ dv/tb_handheld_console_bus_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_handheld_console_bus_decoder
// self-checking bench for the handheld console memory map decoder
// ----------------------------------------------------------------------------
// A shadow of the memory map predicts every access beat as it is accepted.
// The shadow tracks which store cells hold data, so reads only go to cells that
// were loaded or written. A directed part hits each region edge, the echo
// window, unmapped holes, out-of-range loads and the boot overlay. Random
// phases follow: boundary windows plus fully random addresses, with the boot
// overlay toggled between phases. One phase runs without idling and one holds
// the result side off for a long stretch while access beats keep coming.
// ----------------------------------------------------------------------------
module tb_handheld_console_bus_decoder;
  import hcbd_pkg::*;

  localparam int unsigned QUIET_LIMIT     = 1000; // cycles with no handshake at all
  localparam int unsigned HOLD_OFF_CYCLES = 150;  // long result-side back-pressure
  localparam int unsigned SETTLE_CYCLES   = 8;    // quiet time before a config write
  localparam int unsigned PHASE_COUNT     = 6;
  localparam int unsigned PHASE_BEATS     = 320;

  // byte stores of the memory map, used to key the shadow cells
  typedef enum logic [3:0] {
    STORE_ROM, STORE_BOOT, STORE_VRAM, STORE_ERAM, STORE_WRAM,
    STORE_OAM, STORE_IO, STORE_DISPLAY, STORE_HRAM
  } store_e;

  // shadow of the memory map: predicts each access and holds the results owed
  class memory_map_shadow;
    logic [7:0] cells [int]; // only cells that hold data are present
    logic [7:0] ie_reg;
    bit         overlay;
    out_beat_t  owed [$];
    int         failures;

    function new();
      ie_reg   = '0;
      overlay  = 1'b0;
      failures = 0;
    endfunction

    function int key_of(store_e s, logic [15:0] idx);
      return (int'(s) << 16) | int'(idx);
    endfunction

    function bit in_boot_page(logic [15:0] a);
      return overlay && (a[15:8] == 8'h00);
    endfunction

    // resolve a bus address to a cell; 0 for the unmapped holes
    function bit map_address(logic [15:0] a, output int key, output logic [3:0] rgn,
                             output bit rom_hit, output bit ie_hit);
      key     = 0;
      rgn     = REGION_NONE;
      rom_hit = 1'b0;
      ie_hit  = 1'b0;
      if (a < ADDR_VRAM) begin
        rom_hit = 1'b1;
        key     = key_of(STORE_ROM, a);
      end else if (a < ADDR_ERAM) begin
        rgn = REGION_VRAM;
        key = key_of(STORE_VRAM, a - ADDR_VRAM);
      end else if (a < ADDR_WRAM) begin
        rgn = REGION_ERAM;
        key = key_of(STORE_ERAM, a - ADDR_ERAM);
      end else if (a < ADDR_ECHO) begin
        rgn = REGION_WRAM;
        key = key_of(STORE_WRAM, a - ADDR_WRAM);
      end else if (a < ADDR_OAM) begin
        // echo folds onto work ram from its own base
        rgn = REGION_ECHO;
        key = key_of(STORE_WRAM, a - ADDR_ECHO);
      end else if (a < ADDR_OAM_END) begin
        rgn = REGION_OAM;
        key = key_of(STORE_OAM, a - ADDR_OAM);
      end else if (a < ADDR_IO) begin
        return 1'b0;
      end else if (a == ADDR_IE) begin
        rgn    = REGION_IE;
        ie_hit = 1'b1;
      end else if (a < ADDR_IO_END) begin
        rgn = REGION_IO;
        key = key_of(STORE_IO, {12'h000, a[3:0]});
      end else if (a < ADDR_DISPLAY) begin
        return 1'b0;
      end else if (a < ADDR_HRAM) begin
        rgn = REGION_DISPLAY;
        key = key_of(STORE_DISPLAY, a - ADDR_DISPLAY);
      end else begin
        rgn = REGION_HRAM;
        key = key_of(STORE_HRAM, {9'h000, a[6:0]});
      end
      return 1'b1;
    endfunction

    // true when a read of this byte touches no cell that lacks data
    function bit byte_known(logic [15:0] a);
      int         key;
      logic [3:0] rgn;
      bit         rom_hit;
      bit         ie_hit;
      if (in_boot_page(a)) return cells.exists(key_of(STORE_BOOT, a));
      if (!map_address(a, key, rgn, rom_hit, ie_hit)) return 1'b1;
      if (ie_hit) return 1'b1;
      return cells.exists(key);
    endfunction

    function bit may_read(logic [15:0] a, logic is_word);
      return byte_known(a) && (!is_word || byte_known(a + 16'd1));
    endfunction

    function logic [7:0] fetch_byte(logic [15:0] a);
      int         key;
      logic [3:0] rgn;
      bit         rom_hit;
      bit         ie_hit;
      if (in_boot_page(a)) return cells[key_of(STORE_BOOT, a)];
      if (!map_address(a, key, rgn, rom_hit, ie_hit)) return 8'h00;
      if (ie_hit) return ie_reg;
      return cells[key];
    endfunction

    function logic [3:0] store_byte(logic [15:0] a, logic [7:0] d);
      int         key;
      logic [3:0] rgn;
      bit         rom_hit;
      bit         ie_hit;
      if (in_boot_page(a)) return REGION_NONE;
      if (!map_address(a, key, rgn, rom_hit, ie_hit) || rom_hit) return REGION_NONE;
      if (ie_hit) ie_reg = d;
      else cells[key] = d;
      return rgn;
    endfunction

    function void fill_rom_byte(bit to_boot, logic [15:0] off, logic [7:0] d);
      if (to_boot) begin
        if (off < BOOT_SIZE) cells[key_of(STORE_BOOT, off)] = d;
      end else begin
        // cartridge rom spans the space below video ram
        if (off < ADDR_VRAM) cells[key_of(STORE_ROM, off)] = d;
      end
    endfunction

    // an access beat was accepted: update the shadow and queue its result
    function void take_access(in_beat_t b);
      out_beat_t   r;
      logic [15:0] hi_addr;
      logic [3:0]  hi_region;
      bit          to_boot;
      r       = '0;
      hi_addr = b.address + 16'd1;
      to_boot = (b.kind == KIND_LOAD_BOOT);
      case (b.kind)
        KIND_READ: begin
          r.read_data[7:0] = fetch_byte(b.address);
          if (b.is_word) r.read_data[15:8] = fetch_byte(hi_addr);
        end
        KIND_WRITE: begin
          r.write_region = store_byte(b.address, b.write_data[7:0]);
          if (b.is_word) begin
            hi_region      = store_byte(hi_addr, b.write_data[15:8]);
            r.write_region = r.write_region & hi_region;
          end
        end
        default: begin
          fill_rom_byte(to_boot, b.address, b.write_data[7:0]);
          if (b.is_word) fill_rom_byte(to_boot, hi_addr, b.write_data[15:8]);
          if (to_boot) overlay = 1'b1;
        end
      endcase
      owed.push_back(r);
    endfunction

    function void check_response(out_beat_t got);
      out_beat_t want;
      if (owed.size() == 0) begin
        $error("result beat with no access pending: read_data %h write_region %0d",
               got.read_data, got.write_region);
        failures++;
        return;
      end
      want = owed.pop_front();
      if (got.read_data !== want.read_data) begin
        $error("read_data: expected %h, got %h", want.read_data, got.read_data);
        failures++;
      end
      if (got.write_region !== want.write_region) begin
        $error("write_region: expected %0d, got %0d", want.write_region, got.write_region);
        failures++;
      end
    endfunction
  endclass

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_beat_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_beat_t out_data_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic      cfg_data_i  = 1'b0;

  memory_map_shadow mem_map;
  bit               idling_on        = 1'b1;
  bit               hold_off_request = 1'b0;
  int unsigned      quiet_cycles     = 0;

  handheld_console_bus_decoder DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // watchdog: any handshake resets the count, a long silence ends the run
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        cfg_valid_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stall before each beat, one long hold-off on request
  initial begin : result_side
    int unsigned hold;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_off_request) begin
        hold             = HOLD_OFF_CYCLES;
        hold_off_request = 1'b0;
      end else begin
        hold = idling_on ? $urandom_range(0, 3) : 0;
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      // values seen here are the ones that stood before the edge
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      mem_map.check_response(out_data_o);
    end
  end

  // offer one access beat after a random gap and wait until it is taken;
  // valid stays high into the next beat when no gap is drawn
  task automatic send_access(in_beat_t beat);
    int unsigned gap;
    gap = idling_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    mem_map.take_access(beat);
  endtask

  // drop valid, wait for every owed result, then let the pipe go quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (mem_map.owed.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_overlay(logic v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    mem_map.overlay = v;
  endtask

  // mostly a 32-byte window straddling a region boundary, sometimes anywhere
  function automatic logic [15:0] pick_address();
    logic [15:0] base;
    if ($urandom_range(0, 7) == 0) return 16'($urandom);
    case ($urandom_range(0, 12))
      0:       base = 16'h0000;
      1:       base = BOOT_SIZE;
      2:       base = ADDR_VRAM;
      3:       base = ADDR_ERAM;
      4:       base = ADDR_WRAM;
      5:       base = ADDR_ECHO;
      6:       base = ADDR_OAM;
      7:       base = ADDR_OAM_END;
      8:       base = ADDR_IO;
      9:       base = ADDR_IO_END;
      10:      base = ADDR_DISPLAY;
      11:      base = ADDR_HRAM;
      default: base = ADDR_IE;
    endcase
    return base + 16'($urandom_range(0, 31)) - 16'd16;
  endfunction

  function automatic in_beat_t random_access(bit boot_ok);
    in_beat_t    b;
    int unsigned pick;
    int unsigned tries;
    b.is_word    = 1'($urandom_range(0, 1));
    b.write_data = 16'($urandom);
    pick         = $urandom_range(0, 99);
    if (pick < 40) b.kind = KIND_READ;
    else if (pick < 75) b.kind = KIND_WRITE;
    else if (pick < 97 || !boot_ok) b.kind = KIND_LOAD_ROM;
    else b.kind = KIND_LOAD_BOOT;
    b.address = pick_address();
    if (b.kind == KIND_READ) begin
      // steer reads onto cells that hold data
      tries = 0;
      while (!mem_map.may_read(b.address, b.is_word) && tries < 12) begin
        b.address = pick_address();
        tries++;
      end
      if (!mem_map.may_read(b.address, b.is_word)) begin
        b.address = ADDR_IE;
        b.is_word = 1'b0;
      end
    end
    return b;
  endfunction

  initial begin : stimulus
    mem_map = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_overlay(1'b0);

    // interrupt enable straight out of reset
    send_access('{KIND_READ,      1'b0, ADDR_IE,  16'h0000});
    // rom loads, including the top edge and offsets past the end
    send_access('{KIND_LOAD_ROM,  1'b1, 16'h0000, 16'hA55A});
    send_access('{KIND_LOAD_ROM,  1'b1, 16'h7FFF, 16'h1234});
    send_access('{KIND_LOAD_ROM,  1'b1, 16'hFFFF, 16'hBEEF});
    send_access('{KIND_LOAD_ROM,  1'b1, 16'h00FF, 16'hC3C3});
    // one write per region, edges of each
    send_access('{KIND_WRITE,     1'b0, ADDR_VRAM, 16'h0011});
    send_access('{KIND_WRITE,     1'b0, 16'hBFFF, 16'h0022});
    send_access('{KIND_WRITE,     1'b1, ADDR_WRAM, 16'h4433});
    send_access('{KIND_WRITE,     1'b0, 16'hFDFF, 16'h0055});
    send_access('{KIND_WRITE,     1'b0, ADDR_OAM, 16'h0066});
    send_access('{KIND_WRITE,     1'b0, 16'hFF0F, 16'h0077});
    send_access('{KIND_WRITE,     1'b0, ADDR_DISPLAY, 16'h0088});
    // word across high ram and interrupt enable
    send_access('{KIND_WRITE,     1'b1, 16'hFFFE, 16'h9966});
    // unmapped holes and rom writes report none
    send_access('{KIND_WRITE,     1'b0, ADDR_OAM_END, 16'h00AA});
    send_access('{KIND_WRITE,     1'b1, 16'hFF3F, 16'hBBCC});
    send_access('{KIND_WRITE,     1'b0, 16'h1234, 16'h00DD});
    // work ram top plus echo base: region codes and together to none
    send_access('{KIND_WRITE,     1'b1, 16'hDFFF, 16'hEEFF});
    send_access('{KIND_READ,      1'b1, ADDR_ECHO, 16'h0000});
    // word read wraps from the top of the map into rom
    send_access('{KIND_READ,      1'b1, ADDR_IE,  16'h0000});
    send_access('{KIND_READ,      1'b1, 16'h7FFF, 16'h0000});
    send_access('{KIND_READ,      1'b1, 16'hFF3F, 16'h0000});
    // boot rom loads turn the overlay on; past the end is dropped
    send_access('{KIND_LOAD_BOOT, 1'b1, 16'h00FF, 16'h9A5C});
    send_access('{KIND_LOAD_BOOT, 1'b0, BOOT_SIZE, 16'h0011});
    send_access('{KIND_LOAD_BOOT, 1'b0, 16'h0000, 16'h00F0});
    // overlay read crossing out of page zero, and an ignored page-zero write
    send_access('{KIND_READ,      1'b1, 16'h00FF, 16'h0000});
    send_access('{KIND_WRITE,     1'b0, 16'h0010, 16'h0012});
    settle();

    // random phases; overlay on for even phases, off for odd ones where boot
    // loads wait until late so most of the phase runs without the overlay
    for (int unsigned phase = 0; phase < PHASE_COUNT; phase++) begin
      write_overlay(phase % 2 == 0);
      idling_on = (phase != 2);
      if (phase == 3) hold_off_request = 1'b1;
      for (int unsigned i = 0; i < PHASE_BEATS; i++) begin
        send_access(random_access(phase % 2 == 0 || i > 260));
      end
      settle();
    end

    if (mem_map.failures == 0 && mem_map.owed.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
